@@ rtl/core/euler_angles_to_quaternion_assert.svh @@
// ---------------------------------------------------------------------------
// euler to quaternion assertion macros
// shared wrappers for concurrent checks on the top level
// ---------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_QUATERNION_ASSERT_SVH
`define EULER_ANGLES_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTHESIS
`define EQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define EQ_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define EQ_ASSERT(label, clk, rst, prop)
`define EQ_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ rtl/core/eaq_pkg.sv @@
// ---------------------------------------------------------------------------
// eaq_pkg
// constants and tables for the euler to quaternion converter
// ---------------------------------------------------------------------------
`default_nettype none
package eaq_pkg;
  localparam int CordicIterations = 16;
  localparam int TableLen = 24;
  localparam int AngleW = 16;
  localparam int QuatW = 16;
  localparam int CordW = 34;
  localparam int TrigW = 19;
  localparam logic signed [AngleW-1:0] AngleLimit = 16'sd25736;
  localparam logic signed [CordW-1:0] GainQ30 = 34'sh026DD3B6A;
  localparam logic signed [QuatW-1:0] Q14One = 16'sd16384;

  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CordW-1:0] r;
    case (i)
      5'd0: r = 34'sh03243F6A8;   5'd1: r = 34'sh01DAC6705;
      5'd2: r = 34'sh00FADBAFC;   5'd3: r = 34'sh007F56EA6;
      5'd4: r = 34'sh003FEAB76;   5'd5: r = 34'sh001FFD55B;
      5'd6: r = 34'sh000FFFAAA;   5'd7: r = 34'sh0007FFF55;
      5'd8: r = 34'sh0003FFFEA;   5'd9: r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;  5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;  5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;  5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;  5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;  5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;  5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;  5'd23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/eaq_cordic.sv @@
// ---------------------------------------------------------------------------
// eaq_cordic
// pipelined rotation-mode cordic, one stage per iteration, half-angle sin/cos
// ---------------------------------------------------------------------------
`default_nettype none
module eaq_cordic #(
  parameter int ITERS = eaq_pkg::CordicIterations
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic signed [eaq_pkg::AngleW-1:0]      angle,
  output logic signed [eaq_pkg::TrigW-1:0]            cos_q16,
  output logic signed [eaq_pkg::TrigW-1:0]            sin_q16
);
  import eaq_pkg::*;
  localparam int N = (ITERS < TableLen) ? ITERS : TableLen;

  logic signed [CordW-1:0] x [N+1];
  logic signed [CordW-1:0] y [N+1];
  logic signed [CordW-1:0] z [N+1];
  logic signed [AngleW-1:0] ang_sat;

  always_comb begin
    ang_sat = angle;
    if (angle > AngleLimit) ang_sat = AngleLimit;
    if (angle < -AngleLimit) ang_sat = -AngleLimit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= GainQ30;
      y[0] <= '0;
      z[0] <= {{(CordW-AngleW-16){ang_sat[AngleW-1]}}, ang_sat, 16'd0};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][CordW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_q30(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_q30(5'(i));
        end
      end
    end
  end

  logic signed [CordW-1:0] xr, yr;
  assign xr = (x[N] + CordW'(8192)) >>> 14;
  assign yr = (y[N] + CordW'(8192)) >>> 14;
  assign cos_q16 = xr[TrigW-1:0];
  assign sin_q16 = yr[TrigW-1:0];
endmodule
`default_nettype wire

@@ rtl/core/eaq_merge.sv @@
// ---------------------------------------------------------------------------
// eaq_merge
// combines lane sin/cos into quaternion: two product stages, sum, round, clip
// ---------------------------------------------------------------------------
`default_nettype none
module eaq_merge (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [eaq_pkg::TrigW-1:0]    c1, s1, c2, s2, c3, s3,
  output logic signed [eaq_pkg::QuatW-1:0]         q0, q1, q2, q3
);
  import eaq_pkg::*;
  localparam int PW = 2*TrigW;
  localparam int TW = 3*TrigW;

  logic signed [PW-1:0] cc, ss, sc, cs;
  logic signed [TrigW-1:0] c3d, s3d;
  logic signed [TW-1:0] t [8];
  logic signed [TW:0] sum [4];

  always_ff @(posedge clk) begin
    if (en) begin
      cc <= c1 * c2; ss <= s1 * s2; sc <= s1 * c2; cs <= c1 * s2;
      c3d <= c3; s3d <= s3;
      t[0] <= cc * c3d; t[1] <= ss * s3d;
      t[2] <= sc * c3d; t[3] <= cs * s3d;
      t[4] <= cs * c3d; t[5] <= sc * s3d;
      t[6] <= cc * s3d; t[7] <= ss * c3d;
    end
  end

  always_comb begin
    sum[0] = (TW+1)'(t[0]) + (TW+1)'(t[1]);
    sum[1] = (TW+1)'(t[2]) - (TW+1)'(t[3]);
    sum[2] = (TW+1)'(t[4]) + (TW+1)'(t[5]);
    sum[3] = (TW+1)'(t[6]) - (TW+1)'(t[7]);
  end

  function automatic logic signed [QuatW-1:0] fin(input logic signed [TW:0] v);
    logic signed [TW:0] r;
    r = (v + ((TW+1)'(1) <<< 33)) >>> 34;
    if (r > (TW+1)'(Q14One)) return Q14One;
    if (r < -(TW+1)'(Q14One)) return -Q14One;
    return r[QuatW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= fin(sum[0]); q1 <= fin(sum[1]);
      q2 <= fin(sum[2]); q3 <= fin(sum[3]);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/euler_angles_to_quaternion.sv @@
// ---------------------------------------------------------------------------
// euler_angles_to_quaternion
// zyx euler angles to attitude quaternion, three cordic lanes and a merge
// ---------------------------------------------------------------------------
// s_axis carries roll, pitch, yaw (Q2.13) in tdata; m_axis returns
// q0..q3 (Q1.14) in tdata. One transaction per cycle sustained while
// m_axis_tready is high. The path is one input register, one register
// per cordic stage, two multiply stages and a round/saturate register.
// The whole pipeline advances together; when m_axis_tready is low and the
// output holds a result, the pipeline freezes and s_axis_tready drops, so
// the output register parts the sides only as a freeze point.
// A valid bit per stage tracks occupancy; under a stall every stage holds,
// bubbles included, so empty slots are not squeezed out.
// Reset clears the valid bits only; payload is not reset.
// ---------------------------------------------------------------------------
`default_nettype none
`include "euler_angles_to_quaternion_assert.svh"
module euler_angles_to_quaternion #(
  parameter int CORDIC_ITERATIONS = eaq_pkg::CordicIterations
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // quat_scalar, quat_x, quat_y, quat_z
);
  import eaq_pkg::*;
  localparam int N = (CORDIC_ITERATIONS < TableLen) ? CORDIC_ITERATIONS : TableLen;
  localparam int LAT = N + 4;

  logic [LAT-1:0] vld;
  logic en;
  logic signed [TrigW-1:0] c [3];
  logic signed [TrigW-1:0] s [3];
  logic signed [QuatW-1:0] q0, q1, q2, q3;

  // advance unless a finished result is waiting on a stalled sink
  assign en = !vld[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];
  assign m_axis_tdata = {q3, q2, q1, q0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    eaq_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
      .clk(clk), .en(en),
      .angle(s_axis_tdata[16*l +: 16]),
      .cos_q16(c[l]), .sin_q16(s[l])
    );
  end

  eaq_merge u_merge (
    .clk(clk), .en(en),
    .c1(c[0]), .s1(s[0]), .c2(c[1]), .s2(s[1]), .c3(c[2]), .s3(s[2]),
    .q0(q0), .q1(q1), .q2(q2), .q3(q3)
  );

  `EQ_ASSERT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `EQ_ASSERT(a_ready_when_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready)
  `EQ_ASSERT_RST(a_reset_empty, clk, $past(rst) |-> !m_axis_tvalid)
endmodule
`default_nettype wire
